// File: design/sorted_multi_timer_queue_macros.svh
// Assertion macros for the sorted multi-timer queue.
// Included by the top level; no other dependencies.
`ifndef SORTED_MULTI_TIMER_QUEUE_MACROS_SVH
`define SORTED_MULTI_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTH
`define SMTQ_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("smtq check failed");
`define SMTQ_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("smtq check failed");
`else
`define SMTQ_ASSERT_IMPL(name, clk, rst, pre, post)
`define SMTQ_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// File: design/smtq_pkg.sv
// Shared types and constants of the sorted multi-timer queue.
// No dependencies.
package smtq_pkg;
   localparam int OP_W = 3;
   localparam int IDX_W = 4;
   localparam int TIME_W = 32;
   localparam int DATA_W = 8;
   localparam int KIND_W = 2;
   localparam int MAX_OUT = 16;
   localparam int OUTN_W = 5;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [1:0] tstate_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam op_type OP_ALLOC = 3'd0;
   localparam op_type OP_FREE = 3'd1;
   localparam op_type OP_SET_DATA = 3'd2;
   localparam op_type OP_START = 3'd3;
   localparam op_type OP_TICK = 3'd4;

   localparam kind_type KIND_GRANT = 2'd0;
   localparam kind_type KIND_NO_FREE = 2'd1;
   localparam kind_type KIND_EXPIRED = 2'd2;
   localparam kind_type KIND_REJECT = 2'd3;

   localparam tstate_type TS_UNUSED = 2'd0;
   localparam tstate_type TS_ALLOC = 2'd1;
   localparam tstate_type TS_RUN = 2'd2;

   localparam time_type NO_DEADLINE = 32'hffff_ffff;
endpackage

// File: design/smtq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/sorted_multi_timer_queue.sv
// Sorted multi-timer queue: timer pool, tick counter and deadline-ordered run queue.
// Depends on smtq_pkg, smtq_ram and sorted_multi_timer_queue_macros.svh.
//
// Usage: drive req_* and raise start; a transaction is taken at an edge where start
// is high and busy is low. Allocate answers in the cycle after acceptance with one
// result and leaves busy low. Free and set data finish in the accepting cycle.
// A start writes the deadline, then scans the queue (per entry: a slot read, a
// deadline read and the compare), moves the tail up one entry (a read and a write
// per moved entry) and reloads the cached next deadline (a slot read, a deadline
// read and the load). A start on a full queue answers in the cycle after
// acceptance with a reject. A tick that does not reach the cached deadline
// finishes at once; otherwise it pops expired entries (a slot read, a deadline read
// and the compare each, at most 16 per tick), then reloads the cached deadline.
// The registered read ports of the slot and deadline memories set these steps.
// Results appear on rsp_* for exactly one cycle with rsp_valid high; rsp_last
// marks the final result of a transaction. The receiver cannot stall.
// Reset clears the tick count, queue length and timer states and sets the cached
// deadline to all ones; memory contents are left as they are.
module sorted_multi_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [smtq_pkg::OP_W-1:0]      req_operation,
   input  logic [smtq_pkg::IDX_W-1:0]     req_timer_index,
   input  logic [smtq_pkg::TIME_W-1:0]    req_timeout,
   input  logic [smtq_pkg::DATA_W-1:0]    req_data,
   output logic                           rsp_valid,
   output logic [smtq_pkg::KIND_W-1:0]    rsp_kind,
   output logic [smtq_pkg::IDX_W-1:0]     rsp_result_index,
   output logic [smtq_pkg::DATA_W-1:0]    rsp_payload,
   output logic                           rsp_last
);
   import smtq_pkg::*;

   localparam int NT = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
   localparam int TAW = $clog2(NT);
   localparam int AW = $clog2(NUM_TIMERS);
   localparam int QDEPTH = 1 << AW;
   localparam int LW = $clog2(NUM_TIMERS + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INS_CHK = 4'd1;
   localparam logic [3:0] S_INS_SLOT = 4'd2;
   localparam logic [3:0] S_INS_DL = 4'd3;
   localparam logic [3:0] S_INS_SHIFT = 4'd4;
   localparam logic [3:0] S_INS_MOVE = 4'd5;
   localparam logic [3:0] S_REF_A = 4'd6;
   localparam logic [3:0] S_REF_B = 4'd7;
   localparam logic [3:0] S_REF_C = 4'd8;
   localparam logic [3:0] S_TK_CHK = 4'd9;
   localparam logic [3:0] S_TK_SLOT = 4'd10;
   localparam logic [3:0] S_TK_DL = 4'd11;

   logic [3:0] st_ff, st_in;
   time_type tick_ff, tick_in;
   time_type nd_ff, nd_in;
   tstate_type state_ff [NT];
   tstate_type state_in [NT];
   logic [AW-1:0] head_ff, head_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [OUTN_W-1:0] n_ff, n_in;
   time_type when_ff, when_in;
   logic [TAW-1:0] idx_ff, idx_in;
   logic [TAW-1:0] t_ff, t_in;
   logic pend_ff, pend_in;
   logic [TAW-1:0] pend_idx_ff, pend_idx_in;
   logic [DATA_W-1:0] pend_pay_ff, pend_pay_in;
   logic rsp_valid_ff, rsp_valid_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic rsp_last_ff, rsp_last_in;

   logic q_we;
   logic [AW-1:0] q_waddr, q_raddr;
   logic [TAW-1:0] q_wdata, q_rdata;
   logic d_we;
   logic [TAW-1:0] d_waddr, d_raddr;
   time_type d_wdata, d_rdata;
   logic b_we;
   logic [DATA_W-1:0] b_rdata;

   logic alloc_found;
   logic [TAW-1:0] alloc_idx;
   logic idx_ok;
   logic [TAW-1:0] idx_t;
   time_type tick_next;

   assign idx_ok = 32'(req_timer_index) < NUM_TIMERS;
   assign idx_t = req_timer_index[TAW-1:0];
   assign tick_next = tick_ff + 32'd1;

   // Lowest unused timer wins the allocation.
   always_comb begin
      alloc_found = 1'b0;
      alloc_idx = '0;
      for (int k = 0; k < NT; k++) begin
         if (!alloc_found && state_ff[k] == TS_UNUSED) begin
            alloc_found = 1'b1;
            alloc_idx = TAW'(k);
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      tick_in = tick_ff;
      nd_in = nd_ff;
      state_in = state_ff;
      head_in = head_ff;
      len_in = len_ff;
      i_in = i_ff;
      j_in = j_ff;
      n_in = n_ff;
      when_in = when_ff;
      idx_in = idx_ff;
      t_in = t_ff;
      pend_in = pend_ff;
      pend_idx_in = pend_idx_ff;
      pend_pay_in = pend_pay_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_last_in = rsp_last_ff;
      q_we = 1'b0;
      q_waddr = '0;
      q_wdata = '0;
      q_raddr = head_ff;
      d_we = 1'b0;
      d_waddr = idx_t;
      d_wdata = tick_ff + req_timeout;
      d_raddr = '0;
      b_we = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  OP_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     rsp_pay_in = '0;
                     rsp_last_in = 1'b1;
                     if (alloc_found) begin
                        state_in[alloc_idx] = TS_ALLOC;
                        rsp_kind_in = KIND_GRANT;
                        rsp_index_in = IDX_W'(alloc_idx);
                     end else begin
                        rsp_kind_in = KIND_NO_FREE;
                        rsp_index_in = '0;
                     end
                  end
                  OP_FREE: begin
                     if (idx_ok) begin
                        state_in[idx_t] = TS_UNUSED;
                     end
                  end
                  OP_SET_DATA: begin
                     b_we = idx_ok;
                  end
                  OP_START: begin
                     if (idx_ok) begin
                        if (len_ff == LW'(NUM_TIMERS)) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in = KIND_REJECT;
                           rsp_index_in = req_timer_index;
                           rsp_pay_in = '0;
                           rsp_last_in = 1'b1;
                        end else begin
                           d_we = 1'b1;
                           when_in = tick_ff + req_timeout;
                           idx_in = idx_t;
                           state_in[idx_t] = TS_RUN;
                           i_in = '0;
                           st_in = S_INS_CHK;
                        end
                     end
                  end
                  OP_TICK: begin
                     tick_in = tick_next;
                     if (!(nd_ff > tick_next)) begin
                        n_in = '0;
                        pend_in = 1'b0;
                        st_in = S_TK_CHK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_CHK: begin
            q_raddr = AW'(head_ff + i_ff[AW-1:0]);
            if (i_ff == len_ff) begin
               j_in = len_ff;
               st_in = S_INS_SHIFT;
            end else begin
               st_in = S_INS_SLOT;
            end
         end
         S_INS_SLOT: begin
            d_raddr = q_rdata;
            st_in = S_INS_DL;
         end
         S_INS_DL: begin
            if (d_rdata >= when_ff) begin
               j_in = len_ff;
               st_in = S_INS_SHIFT;
            end else begin
               i_in = i_ff + 1'b1;
               st_in = S_INS_CHK;
            end
         end
         S_INS_SHIFT: begin
            q_raddr = AW'(head_ff + j_ff[AW-1:0] - 1'b1);
            if (j_ff == i_ff) begin
               q_we = 1'b1;
               q_waddr = AW'(head_ff + i_ff[AW-1:0]);
               q_wdata = idx_ff;
               len_in = len_ff + 1'b1;
               st_in = S_REF_A;
            end else begin
               st_in = S_INS_MOVE;
            end
         end
         S_INS_MOVE: begin
            q_we = 1'b1;
            q_waddr = AW'(head_ff + j_ff[AW-1:0]);
            q_wdata = q_rdata;
            j_in = j_ff - 1'b1;
            st_in = S_INS_SHIFT;
         end
         S_REF_A: begin
            q_raddr = head_ff;
            if (len_ff == '0) begin
               nd_in = NO_DEADLINE;
               st_in = S_IDLE;
            end else begin
               st_in = S_REF_B;
            end
         end
         S_REF_B: begin
            d_raddr = q_rdata;
            st_in = S_REF_C;
         end
         S_REF_C: begin
            nd_in = d_rdata;
            st_in = S_IDLE;
         end
         S_TK_CHK: begin
            q_raddr = head_ff;
            if (len_ff == '0 || n_ff == OUTN_W'(MAX_OUT)) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in = KIND_EXPIRED;
                  rsp_index_in = IDX_W'(pend_idx_ff);
                  rsp_pay_in = pend_pay_ff;
                  rsp_last_in = 1'b1;
               end
               pend_in = 1'b0;
               st_in = S_REF_A;
            end else begin
               st_in = S_TK_SLOT;
            end
         end
         S_TK_SLOT: begin
            d_raddr = q_rdata;
            t_in = q_rdata;
            st_in = S_TK_DL;
         end
         S_TK_DL: begin
            // A finished result is held back one step so that its last flag is known.
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_EXPIRED;
               rsp_index_in = IDX_W'(pend_idx_ff);
               rsp_pay_in = pend_pay_ff;
               rsp_last_in = d_rdata > tick_ff;
            end
            if (d_rdata > tick_ff) begin
               pend_in = 1'b0;
               st_in = S_REF_A;
            end else begin
               state_in[t_ff] = TS_ALLOC;
               pend_in = 1'b1;
               pend_idx_in = t_ff;
               pend_pay_in = b_rdata;
               n_in = n_ff + 1'b1;
               head_in = head_ff + 1'b1;
               len_in = len_ff - 1'b1;
               st_in = S_TK_CHK;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         tick_ff <= '0;
         nd_ff <= NO_DEADLINE;
         for (int k = 0; k < NT; k++) begin
            state_ff[k] <= TS_UNUSED;
         end
         head_ff <= '0;
         len_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         tick_ff <= tick_in;
         nd_ff <= nd_in;
         state_ff <= state_in;
         head_ff <= head_in;
         len_ff <= len_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      n_ff <= n_in;
      when_ff <= when_in;
      idx_ff <= idx_in;
      t_ff <= t_in;
      pend_idx_ff <= pend_idx_in;
      pend_pay_ff <= pend_pay_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
   end

   smtq_ram #(.WIDTH(TAW), .DEPTH(QDEPTH)) u_slot_ram (
      .clock  (clock),
      .wr_en  (q_we),
      .wr_addr(q_waddr),
      .wr_data(q_wdata),
      .rd_addr(q_raddr),
      .rd_data(q_rdata)
   );

   smtq_ram #(.WIDTH(TIME_W), .DEPTH(NT)) u_deadline_ram (
      .clock  (clock),
      .wr_en  (d_we),
      .wr_addr(d_waddr),
      .wr_data(d_wdata),
      .rd_addr(d_raddr),
      .rd_data(d_rdata)
   );

   smtq_ram #(.WIDTH(DATA_W), .DEPTH(NT)) u_byte_ram (
      .clock  (clock),
      .wr_en  (b_we),
      .wr_addr(idx_t),
      .wr_data(req_data),
      .rd_addr(d_raddr),
      .rd_data(b_rdata)
   );

   assign busy = st_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_payload = rsp_pay_ff;
   assign rsp_last = rsp_last_ff;

`include "sorted_multi_timer_queue_macros.svh"

   `SMTQ_ASSERT_IMPL(a_len_bound, clock, reset, 1'b1, len_ff <= LW'(NUM_TIMERS))
   `SMTQ_ASSERT_IMPL(a_out_bound, clock, reset, 1'b1, n_ff <= OUTN_W'(MAX_OUT) || busy == 1'b0)
   `SMTQ_ASSERT_IMPL(a_mid_busy, clock, reset, rsp_valid && !rsp_last, busy)
   `SMTQ_ASSERT_NEXT(a_alloc_rsp, clock, reset, start && !busy && req_operation == OP_ALLOC, rsp_valid && rsp_last && (rsp_kind == KIND_GRANT || rsp_kind == KIND_NO_FREE))
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sorted multi-timer queue.
// Depends on smtq_pkg and the sorted_multi_timer_queue top level.
`timescale 1ns / 1ps
module testbench;
   import smtq_pkg::*;

   localparam int NT = 16;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   // Operation codes that the block ignores.
   localparam op_type OP_RSVD_A = 3'd5;
   localparam op_type OP_RSVD_B = 3'd6;
   localparam op_type OP_RSVD_C = 3'd7;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] index;
      logic [7:0] payload;
      logic       last;
   } timer_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   op_type      req_operation = OP_TICK;
   logic [3:0]  req_timer_index = '0;
   time_type    req_timeout = '0;
   logic [7:0]  req_data = '0;
   logic        rsp_valid;
   kind_type    rsp_kind;
   logic [3:0]  rsp_result_index;
   logic [7:0]  rsp_payload;
   logic        rsp_last;

   // Predicted state of the timer pool.
   time_type    tick_count;
   time_type    next_due;
   tstate_type  timer_state [NT];
   time_type    due [NT];
   logic [7:0]  expiry_data [NT];
   logic [3:0]  run_queue [NT];
   int          run_len;

   timer_event_type pending_events [$];
   int errors = 0;
   int accepted = 0;
   int events_seen = 0;
   int idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_multi_timer_queue #(.NUM_TIMERS(NT)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_timer_index(req_timer_index),
      .req_timeout(req_timeout), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
      .rsp_result_index(rsp_result_index), .rsp_payload(rsp_payload),
      .rsp_last(rsp_last)
   );

   function automatic timer_event_type make_event(kind_type k, logic [3:0] i,
                                                  logic [7:0] p, logic l);
      timer_event_type e;
      e.kind = k;
      e.index = i;
      e.payload = p;
      e.last = l;
      return e;
   endfunction

   // Applies one transaction to the predicted pool and queues its events.
   task automatic advance_timers(op_type op, logic [3:0] idx, time_type tmo,
                                 logic [7:0] dat);
      int i;
      int n;
      int pos;
      time_type when;
      bit found;
      case (op)
         OP_ALLOC: begin
            found = 0;
            for (i = 0; i < NT && !found; i++) begin
               if (timer_state[i] == TS_UNUSED) begin
                  timer_state[i] = TS_ALLOC;
                  pending_events.push_back(make_event(KIND_GRANT, i[3:0], 8'd0, 1'b1));
                  found = 1;
               end
            end
            if (!found)
               pending_events.push_back(make_event(KIND_NO_FREE, 4'd0, 8'd0, 1'b1));
         end
         OP_FREE: timer_state[idx] = TS_UNUSED;
         OP_SET_DATA: expiry_data[idx] = dat;
         OP_START: begin
            if (run_len >= NT) begin
               pending_events.push_back(make_event(KIND_REJECT, idx, 8'd0, 1'b1));
            end else begin
               when = tick_count + tmo;
               due[idx] = when;
               timer_state[idx] = TS_RUN;
               pos = run_len;
               for (i = run_len - 1; i >= 0; i--)
                  if (due[run_queue[i]] >= when) pos = i;
               // The insert point is the first entry whose deadline is not earlier.
               pos = 0;
               while (pos < run_len && due[run_queue[pos]] < when) pos++;
               for (i = run_len; i > pos; i--) run_queue[i] = run_queue[i-1];
               run_queue[pos] = idx;
               run_len++;
               next_due = due[run_queue[0]];
            end
         end
         OP_TICK: begin
            tick_count++;
            if (next_due <= tick_count) begin
               n = 0;
               while (n < run_len && n < MAX_OUT && due[run_queue[n]] <= tick_count) begin
                  timer_state[run_queue[n]] = TS_ALLOC;
                  pending_events.push_back(make_event(KIND_EXPIRED, run_queue[n],
                                                      expiry_data[run_queue[n]], 1'b0));
                  n++;
               end
               for (i = 0; i < run_len - n; i++) run_queue[i] = run_queue[i+n];
               run_len -= n;
               next_due = (run_len > 0) ? due[run_queue[0]] : NO_DEADLINE;
               if (n > 0) pending_events[$].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send(op_type op, logic [3:0] idx, time_type tmo, logic [7:0] dat);
      int gap;
      req_operation <= op;
      req_timer_index <= idx;
      req_timeout <= tmo;
      req_data <= dat;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      advance_timers(op, idx, tmo, dat);
      accepted++;
      gap = $urandom_range(0, 99);
      if (gap < 70) gap = 0;
      else if (gap < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      timer_event_type want;
      if (!reset && rsp_valid) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            $error("unexpected result kind=%0d index=%0d", rsp_kind, rsp_result_index);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_result_index !== want.index) begin
               $error("result_index: expected %0d, got %0d", want.index, rsp_result_index);
               errors++;
            end
            if (rsp_payload !== want.payload) begin
               $error("payload: expected %0d, got %0d", want.payload, rsp_payload);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog: no accepted transaction and no result for too long.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("FAILURE");
         $finish;
      end
   end

   // Every timer gets a data byte first, so no expiry ever reports an unset byte.
   task automatic test_data_setup();
      int i;
      for (i = 0; i < NT; i++)
         send(OP_SET_DATA, i[3:0], '0, (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom));
   endtask

   task automatic test_alloc_free();
      int i;
      for (i = 0; i <= NT; i++) send(OP_ALLOC, 4'($urandom), time_type'($urandom), 8'd0);
      send(OP_FREE, 4'd15, '0, 8'd0);
      send(OP_FREE, 4'd3, '0, 8'd0);
      send(OP_ALLOC, 4'd0, '0, 8'd0);
      send(OP_RSVD_A, 4'd1, '0, 8'd0);
      send(OP_RSVD_B, 4'd2, '0, 8'd0);
      send(OP_RSVD_C, 4'd15, 32'hffff_ffff, 8'hff);
   endtask

   task automatic test_queue_full();
      int i;
      // Duplicate start of timer 0, then fill the queue and overflow it.
      send(OP_START, 4'd0, 32'd3, 8'd0);
      for (i = 0; i < NT; i++) send(OP_START, i[3:0], (i == 4) ? 32'd2 : 32'd3, 8'd0);
      send(OP_START, 4'd9, 32'd1, 8'd0);
      // Wrapped deadline lands just behind the count.
      repeat (3) send(OP_TICK, '0, '0, 8'd0);
      send(OP_START, 4'd7, 32'hffff_ffff, 8'd0);
      send(OP_START, 4'd8, 32'd0, 8'd0);
      repeat (2) send(OP_TICK, '0, '0, 8'd0);
   endtask

   task automatic test_random(int count);
      int k;
      int sel;
      time_type tmo;
      for (k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         tmo = ($urandom_range(0, 9) == 0) ? time_type'($urandom)
                                           : time_type'($urandom_range(0, 20));
         if (sel < 40) send(OP_TICK, 4'($urandom), time_type'($urandom), 8'($urandom));
         else if (sel < 65) send(OP_START, 4'($urandom), tmo, 8'($urandom));
         else if (sel < 75) send(OP_ALLOC, 4'($urandom), time_type'($urandom), 8'($urandom));
         else if (sel < 85) send(OP_FREE, 4'($urandom), time_type'($urandom), 8'($urandom));
         else if (sel < 95) send(OP_SET_DATA, 4'($urandom), tmo, 8'($urandom));
         else send(op_type'($urandom_range(OP_RSVD_A, OP_RSVD_C)), 4'($urandom), tmo,
                   8'($urandom));
      end
   endtask

   initial begin
      int i;
      tick_count = '0;
      next_due = NO_DEADLINE;
      run_len = 0;
      for (i = 0; i < NT; i++) timer_state[i] = TS_UNUSED;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_data_setup();
      test_alloc_free();
      test_queue_full();
      test_random(356);
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d results never arrived", pending_events.size());
         errors++;
      end
      $display("Ran %0d transactions covering allocate, free, data, start and tick;",
               accepted);
      $display("checked %0d results with %0d mismatches.", events_seen, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
